FILE: hdl/reciprocal_lattice_3x3_assert.svh
// assertion macros for the reciprocal lattice block
// no dependencies; included by the top level, which carries the checks
`ifndef RECIPROCAL_LATTICE_3X3_ASSERT_SVH
`define RECIPROCAL_LATTICE_3X3_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, held off during reset
`define RL3_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rl3 check failed");
// next-cycle implication, held off during reset
`define RL3_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rl3 check failed");
`else
`define RL3_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RL3_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/rl3_pkg.sv
// shared constants and width helpers for the reciprocal lattice block
// no dependencies
package rl3_pkg;

  localparam int NUM_ENT = 9;
  localparam int CFG_W = 32;
  localparam logic [CFG_W-1:0] THR_RESET = 32'd282;

  // 2*pi as unsigned Q3.28
  localparam int TWO_PI_W = 31;
  localparam int TWO_PI_FRAC = 28;
  localparam logic [TWO_PI_W-1:0] TWO_PI_Q28 = 31'h6487ED51;

  // cofactor k = a[P]*a[Q] - a[R]*a[S], entries numbered row*3+col
  localparam logic [3:0] COF_P [NUM_ENT] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
  localparam logic [3:0] COF_Q [NUM_ENT] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
  localparam logic [3:0] COF_R [NUM_ENT] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
  localparam logic [3:0] COF_S [NUM_ENT] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

  // remainder width of the divider for data width w and fraction bits f
  function automatic int rl3_rem_w(input int w, input int f);
    int a;
    int b;
    a = (2 * w + 1) + TWO_PI_W + 2 * f + 1;
    b = (3 * w + 3) + TWO_PI_FRAC + 1 + w;
    return ((a > b) ? a : b) + 1;
  endfunction

endpackage

FILE: hdl/rl3_ifs.sv
// handshake channels for matrix items and reciprocal items
// no dependencies
interface rl3_lat_if #(parameter int DATA_WIDTH = 32);
  logic valid;
  logic ready;
  logic signed [DATA_WIDTH-1:0] lat_r0_c0, lat_r0_c1, lat_r0_c2;
  logic signed [DATA_WIDTH-1:0] lat_r1_c0, lat_r1_c1, lat_r1_c2;
  logic signed [DATA_WIDTH-1:0] lat_r2_c0, lat_r2_c1, lat_r2_c2;
  modport source(output valid, lat_r0_c0, lat_r0_c1, lat_r0_c2, lat_r1_c0, lat_r1_c1,
                 lat_r1_c2, lat_r2_c0, lat_r2_c1, lat_r2_c2, input ready);
  modport sink(input valid, lat_r0_c0, lat_r0_c1, lat_r0_c2, lat_r1_c0, lat_r1_c1,
               lat_r1_c2, lat_r2_c0, lat_r2_c1, lat_r2_c2, output ready);
endinterface

interface rl3_rec_if #(parameter int DATA_WIDTH = 32);
  logic valid;
  logic ready;
  logic signed [DATA_WIDTH-1:0] rec_r0_c0, rec_r0_c1, rec_r0_c2;
  logic signed [DATA_WIDTH-1:0] rec_r1_c0, rec_r1_c1, rec_r1_c2;
  logic signed [DATA_WIDTH-1:0] rec_r2_c0, rec_r2_c1, rec_r2_c2;
  logic singular;
  logic saturated;
  modport source(output valid, rec_r0_c0, rec_r0_c1, rec_r0_c2, rec_r1_c0, rec_r1_c1,
                 rec_r1_c2, rec_r2_c0, rec_r2_c1, rec_r2_c2, singular, saturated,
                 input ready);
  modport sink(input valid, rec_r0_c0, rec_r0_c1, rec_r0_c2, rec_r1_c0, rec_r1_c1,
               rec_r1_c2, rec_r2_c0, rec_r2_c1, rec_r2_c2, singular, saturated,
               output ready);
endinterface

FILE: hdl/rl3_cof.sv
// cofactor stages: input register, pair products, cofactor differences
// depends on rl3_pkg
module rl3_cof import rl3_pkg::*; #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic [2:0]          en,
  input  logic signed [W-1:0] lat_i [NUM_ENT],
  output logic signed [W-1:0] row0_o [3],
  output logic signed [2*W:0] cof_o [NUM_ENT]
);

  logic signed [W-1:0]   a_r [NUM_ENT];
  logic signed [2*W-1:0] pp_r [NUM_ENT];
  logic signed [2*W-1:0] pn_r [NUM_ENT];
  logic signed [W-1:0]   row1_r [3];
  logic signed [W-1:0]   row2_r [3];
  logic signed [2*W:0]   cof_r [NUM_ENT];

  // input register, pair products, then differences
  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_r <= lat_i;
    end
    if (en[1]) begin
      for (int k = 0; k < NUM_ENT; k++) begin
        pp_r[k] <= a_r[COF_P[k]] * a_r[COF_Q[k]];
        pn_r[k] <= a_r[COF_R[k]] * a_r[COF_S[k]];
      end
      for (int j = 0; j < 3; j++) row1_r[j] <= a_r[j];
    end
    if (en[2]) begin
      for (int k = 0; k < NUM_ENT; k++) begin
        cof_r[k] <= $signed({pp_r[k][2*W-1], pp_r[k]}) - $signed({pn_r[k][2*W-1], pn_r[k]});
      end
      row2_r <= row1_r;
    end
  end

  assign row0_o = row2_r;
  assign cof_o  = cof_r;

endmodule

FILE: hdl/rl3_det.sv
// determinant stages: row-0 products, sum with threshold test, cofactor magnitudes
// depends on rl3_pkg
module rl3_det import rl3_pkg::*; #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic [1:0]          en,
  input  logic signed [W-1:0] row0_i [3],
  input  logic signed [2*W:0] cof_i [NUM_ENT],
  input  logic [CFG_W-1:0]    thr_i,
  output logic [3*W+2:0]      det_o,
  output logic                sing_o,
  output logic [2*W:0]        mag_o [NUM_ENT],
  output logic                neg_o [NUM_ENT]
);

  localparam int DTW = 3 * W + 3;
  localparam int PW  = 2 * W + 1;

  logic signed [PW-1:0]  plo_r [3];
  logic signed [PW-1:0]  phi_r [3];
  logic signed [2*W:0]   cof_r [NUM_ENT];
  logic signed [DTW-1:0] det_c;
  logic                  sing_c;
  logic [DTW-1:0]        det_r;
  logic                  sing_r;
  logic [2*W:0]          mag_r [NUM_ENT];
  logic                  neg_r [NUM_ENT];

  // determinant sum and rejection test
  always_comb begin
    det_c = '0;
    for (int j = 0; j < 3; j++) begin
      det_c = det_c + (DTW'(phi_r[j]) <<< W) + DTW'(plo_r[j]);
    end
    sing_c = det_c[DTW-1] || (det_c == '0) ||
             (det_c < $signed({{(DTW-CFG_W){1'b0}}, thr_i}));
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      // each row-0 product split over the low and high cofactor halves
      for (int j = 0; j < 3; j++) begin
        plo_r[j] <= PW'(row0_i[j]) * PW'($signed({1'b0, cof_i[3*j][W-1:0]}));
        phi_r[j] <= PW'(row0_i[j]) * PW'($signed(cof_i[3*j][2*W:W]));
      end
      cof_r <= cof_i;
    end
    if (en[1]) begin
      det_r  <= det_c;
      sing_r <= sing_c;
      for (int k = 0; k < NUM_ENT; k++) begin
        neg_r[k] <= cof_r[k][2*W];
        mag_r[k] <= cof_r[k][2*W] ? -cof_r[k] : cof_r[k];
      end
    end
  end

  assign det_o  = det_r;
  assign sing_o = sing_r;
  assign mag_o  = mag_r;
  assign neg_o  = neg_r;

endmodule

FILE: hdl/rl3_scl.sv
// scaling stages: magnitude times 2*pi, then dividend, divisor and overflow test
// depends on rl3_pkg
module rl3_scl import rl3_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                         clk,
  input  logic [1:0]                   en,
  input  logic [3*W+2:0]               det_i,
  input  logic                         sing_i,
  input  logic [2*W:0]                 mag_i [NUM_ENT],
  input  logic                         neg_i [NUM_ENT],
  output logic [rl3_rem_w(W, F)-1:0]   rem_o [NUM_ENT],
  output logic [rl3_rem_w(W, F)-1:0]   d_o,
  output logic                         sing_o,
  output logic                         neg_o [NUM_ENT],
  output logic                         ovf_o [NUM_ENT]
);

  localparam int RW  = rl3_rem_w(W, F);
  localparam int MLW = W + TWO_PI_W;
  localparam int MHW = W + 1 + TWO_PI_W;

  logic [MLW-1:0]   mtl_r [NUM_ENT];
  logic [MHW-1:0]   mth_r [NUM_ENT];
  logic [3*W+2:0]   det_r;
  logic             sing5_r;
  logic             neg5_r [NUM_ENT];
  logic [RW-1:0]    num_c [NUM_ENT];
  logic [RW-1:0]    d_c;
  logic [RW-1:0]    rem_r [NUM_ENT];
  logic [RW-1:0]    d_r;
  logic             sing_r;
  logic             neg_r [NUM_ENT];
  logic             ovf_r [NUM_ENT];

  // rounded dividend 2*mag*2pi*2^2F + det*2^28 over divisor det*2^29
  always_comb begin
    d_c = RW'(det_r) << (TWO_PI_FRAC + 1);
    for (int k = 0; k < NUM_ENT; k++) begin
      num_c[k] = (((RW'(mth_r[k]) << W) + RW'(mtl_r[k])) << (2 * F + 1)) +
                 (RW'(det_r) << TWO_PI_FRAC);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      // magnitude times 2*pi as low and high partial products
      for (int k = 0; k < NUM_ENT; k++) begin
        mtl_r[k] <= MLW'(mag_i[k][W-1:0]) * MLW'(TWO_PI_Q28);
        mth_r[k] <= MHW'(mag_i[k][2*W:W]) * MHW'(TWO_PI_Q28);
      end
      det_r   <= det_i;
      sing5_r <= sing_i;
      neg5_r  <= neg_i;
    end
    if (en[1]) begin
      d_r    <= d_c;
      sing_r <= sing5_r;
      neg_r  <= neg5_r;
      for (int k = 0; k < NUM_ENT; k++) begin
        rem_r[k] <= num_c[k];
        // quotient needs more than W bits
        ovf_r[k] <= num_c[k] >= (d_c << W);
      end
    end
  end

  assign rem_o  = rem_r;
  assign d_o    = d_r;
  assign sing_o = sing_r;
  assign neg_o  = neg_r;
  assign ovf_o  = ovf_r;

endmodule

FILE: hdl/rl3_div_step.sv
// one restoring-division stage: settles quotient bit K for all nine lanes
// depends on rl3_pkg
module rl3_div_step import rl3_pkg::*; #(
  parameter int W  = 32,
  parameter int RW = 160,
  parameter int K  = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] rem_i [NUM_ENT],
  input  logic [W-1:0]  q_i [NUM_ENT],
  input  logic          neg_i [NUM_ENT],
  input  logic          ovf_i [NUM_ENT],
  input  logic [RW-1:0] d_i,
  input  logic          sing_i,
  output logic [RW-1:0] rem_o [NUM_ENT],
  output logic [W-1:0]  q_o [NUM_ENT],
  output logic          neg_o [NUM_ENT],
  output logic          ovf_o [NUM_ENT],
  output logic [RW-1:0] d_o,
  output logic          sing_o
);

  localparam logic [W-1:0] QBIT = W'(1) << K;

  logic [RW-1:0] dk_c;
  logic [RW-1:0] rem_r [NUM_ENT];
  logic [W-1:0]  q_r [NUM_ENT];
  logic          neg_r [NUM_ENT];
  logic          ovf_r [NUM_ENT];
  logic [RW-1:0] d_r;
  logic          sing_r;

  assign dk_c = d_i << K;

  // compare and subtract the shifted divisor
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NUM_ENT; k++) begin
        q_r[k] <= q_i[k] | ((rem_i[k] >= dk_c) ? QBIT : '0);
        if (rem_i[k] >= dk_c) begin
          rem_r[k] <= rem_i[k] - dk_c;
        end else begin
          rem_r[k] <= rem_i[k];
        end
      end
      neg_r  <= neg_i;
      ovf_r  <= ovf_i;
      d_r    <= d_i;
      sing_r <= sing_i;
    end
  end

  assign rem_o  = rem_r;
  assign q_o    = q_r;
  assign neg_o  = neg_r;
  assign ovf_o  = ovf_r;
  assign d_o    = d_r;
  assign sing_o = sing_r;

endmodule

FILE: hdl/reciprocal_lattice_3x3.sv
// top level of the reciprocal lattice block: 2*pi times the inverse of a 3x3 matrix
// depends on rl3_pkg, rl3_ifs, rl3_cof, rl3_det, rl3_scl, rl3_div_step and the assert header
//
// Takes one 3x3 matrix of signed fixed-point entries per item and returns 2*pi times
// its inverse, rounded to nearest (ties away from zero) and clamped, with singular and
// saturated flags. A matrix whose determinant is not positive or lies below the
// threshold register gives all-zero entries and singular set. One item enters per cycle
// when the result side keeps up; the restoring divider settles one quotient bit per stage.
// Each stage holds its item while the next one cannot advance, so a stalled result only
// blocks once the stages behind it have filled. The user must write the threshold
// through cfg_we/cfg_wdata only while no item is in flight; the block does not enforce it.
`include "reciprocal_lattice_3x3_assert.svh"
module reciprocal_lattice_3x3 import rl3_pkg::*; #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  rl3_lat_if.sink            in_ch,
  rl3_rec_if.source          out_ch,
  input  logic               cfg_we,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  localparam int W   = DATA_WIDTH;
  localparam int RW  = rl3_rem_w(DATA_WIDTH, FRAC_BITS);
  localparam int NST = DATA_WIDTH + 8;
  localparam int DIV0 = 7;

  logic [CFG_W-1:0]    thr_r;
  logic [NST-1:0]      v_r;
  logic [NST-1:0]      en;
  logic signed [W-1:0] lat [NUM_ENT];
  logic signed [W-1:0] row0 [3];
  logic signed [2*W:0] cof [NUM_ENT];
  logic [3*W+2:0]      det;
  logic                det_sing;
  logic [2*W:0]        mag [NUM_ENT];
  logic                mag_neg [NUM_ENT];

  logic [RW-1:0] dv_rem  [W+1][NUM_ENT];
  logic [W-1:0]  dv_q    [W+1][NUM_ENT];
  logic          dv_neg  [W+1][NUM_ENT];
  logic          dv_ovf  [W+1][NUM_ENT];
  logic [RW-1:0] dv_d    [W+1];
  logic          dv_sing [W+1];

  logic signed [W-1:0] rec_r [NUM_ENT];
  logic                sing_r;
  logic                sat_r;
  logic [W-1:0]        res_c [NUM_ENT];
  logic                sat_c;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // stage advances when empty or when the stage after it advances
  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_ch.ready;
    for (int k = NST - 2; k >= 0; k--) en[k] = !v_r[k] || en[k+1];
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_ch.valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign in_ch.ready = en[0];

  // input fields in row-major order
  assign lat[0] = in_ch.lat_r0_c0;
  assign lat[1] = in_ch.lat_r0_c1;
  assign lat[2] = in_ch.lat_r0_c2;
  assign lat[3] = in_ch.lat_r1_c0;
  assign lat[4] = in_ch.lat_r1_c1;
  assign lat[5] = in_ch.lat_r1_c2;
  assign lat[6] = in_ch.lat_r2_c0;
  assign lat[7] = in_ch.lat_r2_c1;
  assign lat[8] = in_ch.lat_r2_c2;

  rl3_cof #(.W(W)) u_cof (
    .clk    (clk),
    .en     (en[2:0]),
    .lat_i  (lat),
    .row0_o (row0),
    .cof_o  (cof)
  );

  rl3_det #(.W(W)) u_det (
    .clk    (clk),
    .en     (en[4:3]),
    .row0_i (row0),
    .cof_i  (cof),
    .thr_i  (thr_r),
    .det_o  (det),
    .sing_o (det_sing),
    .mag_o  (mag),
    .neg_o  (mag_neg)
  );

  rl3_scl #(.W(W), .F(FRAC_BITS)) u_scl (
    .clk    (clk),
    .en     (en[6:5]),
    .det_i  (det),
    .sing_i (det_sing),
    .mag_i  (mag),
    .neg_i  (mag_neg),
    .rem_o  (dv_rem[0]),
    .d_o    (dv_d[0]),
    .sing_o (dv_sing[0]),
    .neg_o  (dv_neg[0]),
    .ovf_o  (dv_ovf[0])
  );

  // quotient starts empty
  for (genvar k = 0; k < NUM_ENT; k++) begin : g_q0
    assign dv_q[0][k] = '0;
  end

  // divider chain, most significant quotient bit first
  for (genvar i = 0; i < W; i++) begin : g_div
    rl3_div_step #(.W(W), .RW(RW), .K(W - 1 - i)) u_step (
      .clk    (clk),
      .en     (en[DIV0 + i]),
      .rem_i  (dv_rem[i]),
      .q_i    (dv_q[i]),
      .neg_i  (dv_neg[i]),
      .ovf_i  (dv_ovf[i]),
      .d_i    (dv_d[i]),
      .sing_i (dv_sing[i]),
      .rem_o  (dv_rem[i+1]),
      .q_o    (dv_q[i+1]),
      .neg_o  (dv_neg[i+1]),
      .ovf_o  (dv_ovf[i+1]),
      .d_o    (dv_d[i+1]),
      .sing_o (dv_sing[i+1])
    );
  end

  // clamp, apply sign, zero singular items
  always_comb begin
    logic [W-1:0] lim;
    logic [W-1:0] mv;
    logic         lane_sat;
    sat_c = 1'b0;
    for (int k = 0; k < NUM_ENT; k++) begin
      lim = dv_neg[W][k] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      lane_sat = dv_ovf[W][k] || (dv_q[W][k] > lim);
      mv = lane_sat ? lim : dv_q[W][k];
      res_c[k] = dv_sing[W] ? '0 : (dv_neg[W][k] ? -mv : mv);
      sat_c = sat_c || (lane_sat && !dv_sing[W]);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      for (int k = 0; k < NUM_ENT; k++) rec_r[k] <= $signed(res_c[k]);
      sing_r <= dv_sing[W];
      sat_r  <= sat_c;
    end
  end

  assign out_ch.valid     = v_r[NST-1];
  assign out_ch.rec_r0_c0 = rec_r[0];
  assign out_ch.rec_r0_c1 = rec_r[1];
  assign out_ch.rec_r0_c2 = rec_r[2];
  assign out_ch.rec_r1_c0 = rec_r[3];
  assign out_ch.rec_r1_c1 = rec_r[4];
  assign out_ch.rec_r1_c2 = rec_r[5];
  assign out_ch.rec_r2_c0 = rec_r[6];
  assign out_ch.rec_r2_c1 = rec_r[7];
  assign out_ch.rec_r2_c2 = rec_r[8];
  assign out_ch.singular  = sing_r;
  assign out_ch.saturated = sat_r;

  // checks
  `RL3_ASSERT_NXT(a_tail_hold, clk, rst_n, v_r[NST-1] && !out_ch.ready, v_r[NST-1])
  `RL3_ASSERT_IMP(a_sing_no_sat, clk, rst_n, v_r[NST-1] && sing_r, !sat_r && (rec_r[0] == '0))
  `RL3_ASSERT_IMP(a_empty_tail_ready, clk, rst_n, !v_r[NST-1], in_ch.ready)

endmodule

FILE: test/testbench.sv
// testbench for reciprocal_lattice_3x3: directed matrices, then random ones, checked
// against a fixed-point predictor of 2*pi times the inverse
// depends on rl3_pkg, rl3_ifs and the block's rtl
`timescale 1ns / 100ps
module testbench;
  import rl3_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic signed [31:0] e[9];
  } matrix_t;

  typedef struct {
    logic signed [31:0] e[9];
    logic singular;
    logic saturated;
  } recip_t;

  typedef struct {
    matrix_t m;
    bit typed;
    recip_t r;
  } vector_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  rl3_lat_if #(.DATA_WIDTH(32)) lat_ch ();
  rl3_rec_if #(.DATA_WIDTH(32)) rec_ch ();

  reciprocal_lattice_3x3 u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(lat_ch),
    .out_ch(rec_ch),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  recip_t pending_recips[$];
  logic [31:0] threshold;
  int mismatches;
  int cycles;
  int recips_seen;
  bit burst_mode;

  // clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[reciprocal_lattice_3x3] ERROR");
      $finish;
    end
  end

  // 2*pi times the inverse by cofactors, rounded half away from zero and clamped
  function automatic recip_t predict_recip(input matrix_t m, input logic [31:0] thr);
    logic signed [255:0] a[9];
    logic signed [255:0] cof[9];
    logic signed [255:0] det;
    logic signed [255:0] thr_w;
    logic [255:0] mag;
    logic [255:0] den;
    logic [255:0] quo;
    logic [255:0] lim;
    bit neg;
    recip_t r;
    for (int i = 0; i < 9; i++) a[i] = m.e[i];
    cof[0] = a[4] * a[8] - a[5] * a[7];
    cof[1] = a[2] * a[7] - a[1] * a[8];
    cof[2] = a[1] * a[5] - a[2] * a[4];
    cof[3] = a[5] * a[6] - a[3] * a[8];
    cof[4] = a[0] * a[8] - a[2] * a[6];
    cof[5] = a[2] * a[3] - a[0] * a[5];
    cof[6] = a[3] * a[7] - a[4] * a[6];
    cof[7] = a[1] * a[6] - a[0] * a[7];
    cof[8] = a[0] * a[4] - a[1] * a[3];
    det = a[0] * cof[0] + a[1] * cof[3] + a[2] * cof[6];
    thr_w = {224'd0, thr};
    r.saturated = 1'b0;
    if (det <= 0 || det < thr_w) begin
      for (int i = 0; i < 9; i++) r.e[i] = '0;
      r.singular = 1'b1;
      return r;
    end
    r.singular = 1'b0;
    den = det <<< TWO_PI_FRAC;
    for (int i = 0; i < 9; i++) begin
      neg = cof[i] < 0;
      mag = neg ? -cof[i] : cof[i];
      quo = (((mag * {225'd0, TWO_PI_Q28}) << 33) + den) / (den << 1);
      lim = neg ? 256'd2147483648 : 256'd2147483647;
      if (quo > lim) begin
        quo = lim;
        r.saturated = 1'b1;
      end
      r.e[i] = neg ? 32'(-quo) : 32'(quo);
    end
    return r;
  endfunction

  function automatic matrix_t diag_matrix(input logic signed [31:0] d0,
                                          input logic signed [31:0] d1,
                                          input logic signed [31:0] d2);
    matrix_t m;
    for (int i = 0; i < 9; i++) m.e[i] = '0;
    m.e[0] = d0;
    m.e[4] = d1;
    m.e[8] = d2;
    return m;
  endfunction

  // random matrix: mostly scaled near-diagonal ones, some raw noise
  function automatic matrix_t random_matrix();
    matrix_t m;
    int shift;
    if ($urandom_range(0, 3) == 0) begin
      for (int i = 0; i < 9; i++) m.e[i] = $urandom;
    end else begin
      shift = $urandom_range(4, 31);
      for (int i = 0; i < 9; i++) m.e[i] = $signed($urandom) >>> shift;
      for (int i = 0; i < 9; i += 4) begin
        m.e[i] = m.e[i] + ((32'sd1 << $urandom_range(0, 20)) * ($urandom_range(0, 4) == 0 ? -1 : 1));
      end
    end
    return m;
  endfunction

  // offer one matrix item and record what it should give
  task automatic send_matrix(input vector_t v);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      lat_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    lat_ch.lat_r0_c0 <= v.m.e[0];
    lat_ch.lat_r0_c1 <= v.m.e[1];
    lat_ch.lat_r0_c2 <= v.m.e[2];
    lat_ch.lat_r1_c0 <= v.m.e[3];
    lat_ch.lat_r1_c1 <= v.m.e[4];
    lat_ch.lat_r1_c2 <= v.m.e[5];
    lat_ch.lat_r2_c0 <= v.m.e[6];
    lat_ch.lat_r2_c1 <= v.m.e[7];
    lat_ch.lat_r2_c2 <= v.m.e[8];
    lat_ch.valid <= 1'b1;
    do @(posedge clk); while (!lat_ch.ready);
    pending_recips.push_back(v.typed ? v.r : predict_recip(v.m, threshold));
  endtask

  // threshold write once the pipeline has drained
  task automatic set_threshold(input logic [31:0] value);
    lat_ch.valid <= 1'b0;
    while (pending_recips.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    threshold = value;
  endtask

  task automatic send_random(input int count);
    vector_t v;
    v.typed = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      v.m = random_matrix();
      send_matrix(v);
    end
    burst_mode = 1'b0;
  endtask

  // result side: random stalls, one long hold-off so the pipeline backs up
  initial begin
    int stall;
    rec_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 6);
      if (recips_seen == 400) stall = 300;
      if (stall > 0) begin
        rec_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rec_ch.ready <= 1'b1;
      do @(posedge clk); while (!rec_ch.valid);
    end
  end

  // compare each result item with the oldest expectation
  always @(posedge clk) begin
    recip_t got;
    recip_t want;
    bit bad;
    if (rst_n && rec_ch.valid && rec_ch.ready) begin
      recips_seen <= recips_seen + 1;
      got.e[0] = rec_ch.rec_r0_c0;
      got.e[1] = rec_ch.rec_r0_c1;
      got.e[2] = rec_ch.rec_r0_c2;
      got.e[3] = rec_ch.rec_r1_c0;
      got.e[4] = rec_ch.rec_r1_c1;
      got.e[5] = rec_ch.rec_r1_c2;
      got.e[6] = rec_ch.rec_r2_c0;
      got.e[7] = rec_ch.rec_r2_c1;
      got.e[8] = rec_ch.rec_r2_c2;
      got.singular = rec_ch.singular;
      got.saturated = rec_ch.saturated;
      if (pending_recips.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item at cycle %0d", cycles);
      end else begin
        want = pending_recips.pop_front();
        bad = (got.singular !== want.singular) || (got.saturated !== want.saturated);
        for (int i = 0; i < 9; i++) if (got.e[i] !== want.e[i]) bad = 1'b1;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at cycle %0d: singular %0b/%0b saturated %0b/%0b",
                     cycles, want.singular, got.singular, want.saturated, got.saturated);
            for (int i = 0; i < 9; i++)
              $display("  entry %0d expected %0d got %0d", i, want.e[i], got.e[i]);
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    vector_t table_rows[$];
    vector_t v;
    recip_t zero_r;
    for (int i = 0; i < 9; i++) zero_r.e[i] = '0;
    zero_r.singular = 1'b0;
    zero_r.saturated = 1'b0;
    mismatches = 0;
    cycles = 0;
    recips_seen = 0;
    burst_mode = 1'b0;
    threshold = THR_RESET;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    lat_ch.valid = 1'b0;
    lat_ch.lat_r0_c0 = '0; lat_ch.lat_r0_c1 = '0; lat_ch.lat_r0_c2 = '0;
    lat_ch.lat_r1_c0 = '0; lat_ch.lat_r1_c1 = '0; lat_ch.lat_r1_c2 = '0;
    lat_ch.lat_r2_c0 = '0; lat_ch.lat_r2_c1 = '0; lat_ch.lat_r2_c2 = '0;

    // identity: diagonal is 2*pi in Q16.16
    v.m = diag_matrix(32'sh10000, 32'sh10000, 32'sh10000);
    v.typed = 1'b1;
    v.r = zero_r;
    v.r.e[0] = 32'sd411775; v.r.e[4] = 32'sd411775; v.r.e[8] = 32'sd411775;
    table_rows.push_back(v);
    // zero matrix and negative determinant are singular
    v.m = diag_matrix(0, 0, 0);
    v.r = zero_r;
    v.r.singular = 1'b1;
    table_rows.push_back(v);
    v.m = diag_matrix(-32'sh10000, 32'sh10000, 32'sh10000);
    table_rows.push_back(v);
    // determinant of one lsb, below the reset threshold
    v.m = diag_matrix(1, 1, 1);
    table_rows.push_back(v);
    // all entries at the extremes: rank one, determinant zero
    v.m = diag_matrix(0, 0, 0);
    for (int i = 0; i < 9; i++) v.m.e[i] = 32'sh7FFFFFFF;
    table_rows.push_back(v);
    for (int i = 0; i < 9; i++) v.m.e[i] = 32'sh80000000;
    table_rows.push_back(v);
    // tiny diagonal: clamps high, and low for a negative cofactor
    v.m = diag_matrix(8, 8, 8);
    v.r = zero_r;
    v.r.saturated = 1'b1;
    v.r.e[0] = 32'sh7FFFFFFF; v.r.e[4] = 32'sh7FFFFFFF; v.r.e[8] = 32'sh7FFFFFFF;
    table_rows.push_back(v);
    v.m = diag_matrix(-8, -8, 8);
    v.r.e[0] = 32'sh80000000; v.r.e[4] = 32'sh80000000; v.r.e[8] = 32'sh7FFFFFFF;
    table_rows.push_back(v);
    // rows left to the predictor
    v.typed = 1'b0;
    v.m = diag_matrix(16, 16, 16);
    table_rows.push_back(v);
    v.m = diag_matrix(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    table_rows.push_back(v);
    v.m = diag_matrix(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF);
    table_rows.push_back(v);
    v.m = diag_matrix(32'sh20000, 32'sh30000, 32'sh8000);
    v.m.e[1] = 32'sh18000; v.m.e[5] = -32'sh4000; v.m.e[6] = 32'sh7FFF;
    table_rows.push_back(v);
    v.m = diag_matrix(32'sh10000, 32'sh10000, 32'sh10000);
    v.m.e[1] = 32'sh10000;
    v.m.e[2] = -32'sh10001;
    table_rows.push_back(v);
    v.m = diag_matrix(3, 5, 19);
    table_rows.push_back(v);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (table_rows[i]) send_matrix(table_rows[i]);
    send_random(250);

    set_threshold(32'd0);
    v.typed = 1'b1;
    v.m = diag_matrix(0, 0, 0);
    v.r = zero_r;
    v.r.singular = 1'b1;
    send_matrix(v);
    v.typed = 1'b0;
    v.m = diag_matrix(1, 1, 1);
    send_matrix(v);
    send_random(200);

    set_threshold(32'hFFFFFFFF);
    v.m = diag_matrix(32'sh10000, 32'sh10000, 32'sh10000);
    send_matrix(v);
    send_random(200);

    set_threshold($urandom);
    send_random(150);

    set_threshold(32'd1);
    send_random(150);

    lat_ch.valid <= 1'b0;
    while (pending_recips.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_recips.size() == 0) begin
      $display("[reciprocal_lattice_3x3] OK");
    end else begin
      $display("[reciprocal_lattice_3x3] ERROR");
    end
    $finish;
  end

endmodule
